/* rtl/core/hse_pkg.sv */
package hse_pkg;

    // One element offered to the block.
    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
    } t_in_item;

    // One sorted element delivered by the block.
    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               end_of_set;
        logic               dropped;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BUILD_INIT,
        S_BUILD_NEXT,
        S_HELD_LD,
        S_CHILD_RD,
        S_CHILD_CMP,
        S_EXTRACT_NEXT,
        S_SWAP_WR,
        S_EMIT
    } t_state;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_BUILD_INIT,
        OP_BUILD_STEP,
        OP_HELD_LD,
        OP_CHILD_RD,
        OP_CHILD_CMP,
        OP_EXTRACT_INIT,
        OP_SWAP_RD,
        OP_SWAP_WR,
        OP_EMIT_INIT,
        OP_EMIT
    } t_dp_op;

    typedef struct packed {
        logic   store;
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic k_zero;
        logic k_gt1;
        logic leaf;
        logic stop;
        logic emit_last;
    } t_dp_status;

endpackage

/* rtl/core/hse_ram.sv */
module hse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

/* rtl/core/hse_datapath.sv */
module hse_datapath #(
    parameter int CAPACITY = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hse_pkg::t_in_item   i_item,
    input  hse_pkg::t_dp_cmd    i_cmd,
    output hse_pkg::t_dp_status o_status,
    output logic                o_result_valid,
    output hse_pkg::t_result    o_result
);
    import hse_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 2;

    logic [CW-1:0]      r_count, n_count;
    logic               r_overflow, n_overflow;
    logic [CW-1:0]      r_k, n_k;
    logic [CW-1:0]      r_size, n_size;
    logic [AW-1:0]      r_pos, n_pos;
    logic signed [31:0] r_held, n_held;
    logic               r_rd_vld, n_rd_vld;
    logic               r_rd_end, n_rd_end;
    logic               r_rd_drop, n_rd_drop;
    logic               r_out_valid;
    t_result            r_out;

    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [31:0]        w_wdata;
    logic [AW-1:0]      w_raddr_a;
    logic [AW-1:0]      w_raddr_b;
    logic [31:0]        w_q_a;
    logic [31:0]        w_q_b;
    logic signed [31:0] w_rd_a;
    logic signed [31:0] w_rd_b;

    logic [XW-1:0]      w_child;
    logic [XW-1:0]      w_child1;
    logic [XW-1:0]      w_size_x;
    logic               w_leaf;
    logic               w_has_right;
    logic               w_pick_b;
    logic signed [31:0] w_big;
    logic [AW-1:0]      w_big_idx;
    logic               w_stop;
    logic [CW-1:0]      w_k_m1;
    logic               w_has_room;
    logic               w_emit_last;

    hse_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_q_a),
        .o_rdata_b (w_q_b)
    );

    assign w_rd_a      = $signed(w_q_a);
    assign w_rd_b      = $signed(w_q_b);
    assign w_child     = XW'({r_pos, 1'b1});
    assign w_child1    = w_child + XW'(1);
    assign w_size_x    = XW'(r_size);
    assign w_leaf      = (w_child >= w_size_x);
    assign w_has_right = (w_child1 < w_size_x);
    // On equal children the left one wins.
    assign w_pick_b    = w_has_right && (w_rd_b > w_rd_a);
    assign w_big       = w_pick_b ? w_rd_b : w_rd_a;
    assign w_big_idx   = w_pick_b ? w_child1[AW-1:0] : w_child[AW-1:0];
    // A child equal to the held element ends the sift.
    assign w_stop      = !(w_big > r_held);
    assign w_k_m1      = r_k - CW'(1);
    assign w_has_room  = (r_count < CW'(CAPACITY));
    assign w_emit_last = ((r_k + CW'(1)) == r_count);

    assign o_status.k_zero    = (r_k == '0);
    assign o_status.k_gt1     = (r_k > CW'(1));
    assign o_status.leaf      = w_leaf;
    assign o_status.stop      = w_stop;
    assign o_status.emit_last = w_emit_last;

    always_comb begin
        w_raddr_a = '0;
        w_raddr_b = '0;
        case (i_cmd.op)
            OP_BUILD_STEP: w_raddr_a = w_k_m1[AW-1:0];
            OP_CHILD_RD: begin
                w_raddr_a = w_child[AW-1:0];
                w_raddr_b = w_child1[AW-1:0];
            end
            OP_SWAP_RD:    w_raddr_b = w_k_m1[AW-1:0];
            OP_EMIT:       w_raddr_a = r_k[AW-1:0];
            default:       w_raddr_a = '0;
        endcase
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_pos;
        w_wdata = r_held;
        if (i_cmd.store && w_has_room) begin
            w_we    = 1'b1;
            w_waddr = r_count[AW-1:0];
            w_wdata = i_item.value;
        end else begin
            case (i_cmd.op)
                OP_CHILD_RD: w_we = w_leaf;
                OP_CHILD_CMP: begin
                    w_we    = 1'b1;
                    w_wdata = w_stop ? r_held : w_big;
                end
                OP_SWAP_WR: begin
                    w_we    = 1'b1;
                    w_waddr = w_k_m1[AW-1:0];
                    w_wdata = w_rd_a;
                end
                default: w_we = 1'b0;
            endcase
        end
    end

    always_comb begin
        n_count    = r_count;
        n_overflow = r_overflow;
        n_k        = r_k;
        n_size     = r_size;
        n_pos      = r_pos;
        n_held     = r_held;
        n_rd_vld   = 1'b0;
        n_rd_end   = r_rd_end;
        n_rd_drop  = r_rd_drop;
        if (i_cmd.store) begin
            if (w_has_room) begin
                n_count = r_count + CW'(1);
            end else begin
                n_overflow = 1'b1;
            end
        end
        case (i_cmd.op)
            OP_BUILD_INIT: begin
                n_k    = r_count >> 1;
                n_size = r_count;
            end
            OP_BUILD_STEP: begin
                n_pos = w_k_m1[AW-1:0];
                n_k   = w_k_m1;
            end
            OP_HELD_LD:      n_held = w_rd_a;
            OP_CHILD_CMP: begin
                if (!w_stop) begin
                    n_pos = w_big_idx;
                end
            end
            OP_EXTRACT_INIT: n_k = r_count;
            OP_SWAP_WR: begin
                n_held = w_rd_b;
                n_pos  = '0;
                n_size = w_k_m1;
                n_k    = w_k_m1;
            end
            OP_EMIT_INIT:    n_k = '0;
            OP_EMIT: begin
                n_rd_vld  = 1'b1;
                n_rd_end  = w_emit_last;
                n_rd_drop = r_overflow;
                n_k       = r_k + CW'(1);
                if (w_emit_last) begin
                    n_count    = '0;
                    n_overflow = 1'b0;
                end
            end
            default: n_k = r_k;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_overflow  <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_overflow  <= n_overflow;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= r_rd_vld;
        end
        r_k                <= n_k;
        r_size             <= n_size;
        r_pos              <= n_pos;
        r_held             <= n_held;
        r_rd_end           <= n_rd_end;
        r_rd_drop          <= n_rd_drop;
        r_out.sorted_value <= w_rd_a;
        r_out.end_of_set   <= r_rd_end;
        r_out.dropped      <= r_rd_drop;
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule

/* rtl/core/hse_ctrl.sv */
module hse_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_last,
    input  hse_pkg::t_dp_status i_status,
    output logic                o_busy,
    output hse_pkg::t_dp_cmd    o_cmd
);
    import hse_pkg::*;

    t_state r_state, n_state;
    logic   r_extract, n_extract;
    t_state w_sift_ret;

    // After a sift the sequencer returns to the phase it came from.
    assign w_sift_ret = r_extract ? S_EXTRACT_NEXT : S_BUILD_NEXT;
    assign o_busy     = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_extract <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_extract <= n_extract;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_extract    = r_extract;
        o_cmd.store  = 1'b0;
        o_cmd.op     = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.store = 1'b1;
                    if (i_last) begin
                        n_state = S_BUILD_INIT;
                    end
                end
            end
            S_BUILD_INIT: begin
                o_cmd.op  = OP_BUILD_INIT;
                n_extract = 1'b0;
                n_state   = S_BUILD_NEXT;
            end
            S_BUILD_NEXT: begin
                if (i_status.k_zero) begin
                    o_cmd.op  = OP_EXTRACT_INIT;
                    n_extract = 1'b1;
                    n_state   = S_EXTRACT_NEXT;
                end else begin
                    o_cmd.op = OP_BUILD_STEP;
                    n_state  = S_HELD_LD;
                end
            end
            S_HELD_LD: begin
                o_cmd.op = OP_HELD_LD;
                n_state  = S_CHILD_RD;
            end
            S_CHILD_RD: begin
                o_cmd.op = OP_CHILD_RD;
                n_state  = i_status.leaf ? w_sift_ret : S_CHILD_CMP;
            end
            S_CHILD_CMP: begin
                o_cmd.op = OP_CHILD_CMP;
                n_state  = i_status.stop ? w_sift_ret : S_CHILD_RD;
            end
            S_EXTRACT_NEXT: begin
                if (i_status.k_gt1) begin
                    o_cmd.op = OP_SWAP_RD;
                    n_state  = S_SWAP_WR;
                end else begin
                    o_cmd.op = OP_EMIT_INIT;
                    n_state  = S_EMIT;
                end
            end
            S_SWAP_WR: begin
                o_cmd.op = OP_SWAP_WR;
                n_state  = S_CHILD_RD;
            end
            S_EMIT: begin
                o_cmd.op = OP_EMIT;
                if (i_status.emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* rtl/core/heap_sort_engine.sv */
// Heapsort engine for sets of signed 32-bit elements.
// Input channel: an element transfer happens at a rising edge with start high
// and busy low; i_item carries the value and a last flag. Elements are written
// into an internal store, one per cycle while busy stays low. Elements that
// arrive once CAPACITY elements are held are discarded and remembered.
// The transfer marked last raises busy and starts the sort: a max-heap build
// followed by repeated root extraction, all through a two-read, one-write
// store. Each sift level is a child read followed by a compare and write.
// Result channel: o_result_valid strobes for exactly one cycle per sorted
// element, in ascending order, on consecutive cycles. end_of_set marks the
// final one, and dropped is set on every result of a set that lost elements.
// Each result passes the store's read register and then the output register.
// Busy falls as the last read is issued; the two trailing results still drain
// while the next set may start loading. The receiver cannot stall, so no
// result is ever held back. A synchronous active-low reset empties the set,
// clears the overflow mark and aborts any sort or emission in progress.
module heap_sort_engine #(
    parameter int CAPACITY = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  hse_pkg::t_in_item i_item,
    output logic              busy,
    output logic              o_result_valid,
    output hse_pkg::t_result  o_result
);
    import hse_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // The controller sequences the heap phases; of the datapath it only sees status flags.
    hse_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_last   (i_item.last),
        .i_status (w_status),
        .o_busy   (busy),
        .o_cmd    (w_cmd)
    );

    // The datapath owns the element store, the index registers and the
    // output register.
    hse_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    // A transfer marked last always starts a sort.
    a_last_starts_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.last) |=> busy)
        else $error("last transfer did not start a sort");

    // Results of one set are emitted on consecutive cycles.
    a_emit_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.end_of_set) |=> o_result_valid)
        else $error("gap inside a result set");

    // The final result of a set is not followed at once by another result.
    a_end_isolated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.end_of_set) |=> !o_result_valid)
        else $error("result right after end of set");

    // The dropped flag is the same on every result of a set.
    a_dropped_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.end_of_set) |=>
            (o_result.dropped == $past(o_result.dropped)))
        else $error("dropped flag changed within a set");

    // Results appear in ascending order within a set.
    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.end_of_set) |=>
            (o_result.sorted_value >= $past(o_result.sorted_value)))
        else $error("results out of order");

endmodule

/* bench/tb_heap_sort_engine.sv */
// Testbench for heap_sort_engine.
module tb_heap_sort_engine;
    import hse_pkg::*;

    localparam int CAPACITY     = 64;
    // No transfer in either direction for this many cycles means the block hung.
    // The slowest legal gap is a full 64-element sort.
    localparam int STALL_LIMIT  = 20000;
    // Results still drain after busy falls, so wait past the last one
    // to catch anything extra.
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 10;

    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

    // The scoreboard keeps its own copy of the element store. When a transfer
    // marked last arrives, it heapsorts the stored set and queues one expected
    // result per stored element, in ascending order.
    class sorted_set_board;
        logic signed [31:0] elements [CAPACITY];
        int                 fill_level;
        bit                 overflowed;
        t_result            expected_q [$];
        int                 errors;
        int                 results_checked;

        function void sift_down(int root, int heap_size);
            logic signed [31:0] held;
            int                 child;
            held  = elements[root];
            child = 2 * root + 1;
            while (child < heap_size) begin
                // The left child wins a tie between children.
                if (child + 1 < heap_size && elements[child + 1] > elements[child])
                    child++;
                // A child equal to the held element stops the sift.
                if (!(elements[child] > held))
                    break;
                elements[root] = elements[child];
                root           = child;
                child          = 2 * root + 1;
            end
            elements[root] = held;
        endfunction

        function void heapsort(int n);
            logic signed [31:0] swap_tmp;
            for (int k = n / 2; k > 0; k--)
                sift_down(k - 1, n);
            for (int k = n; k > 1; k--) begin
                swap_tmp        = elements[0];
                elements[0]     = elements[k - 1];
                elements[k - 1] = swap_tmp;
                sift_down(0, k - 1);
            end
        endfunction

        function void note_element(t_in_item item);
            t_result exp_res;
            if (fill_level < CAPACITY) begin
                elements[fill_level] = item.value;
                fill_level++;
            end else begin
                overflowed = 1'b1;
            end
            if (item.last) begin
                heapsort(fill_level);
                for (int k = 0; k < fill_level; k++) begin
                    exp_res.sorted_value = elements[k];
                    exp_res.end_of_set   = (k + 1 == fill_level);
                    exp_res.dropped      = overflowed;
                    expected_q.push_back(exp_res);
                end
                fill_level = 0;
                overflowed = 1'b0;
            end
        endfunction

        function void check_result(t_result got);
            t_result exp_res;
            results_checked++;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: value %0d end %0b dropped %0b",
                             got.sorted_value, got.end_of_set, got.dropped);
                return;
            end
            exp_res = expected_q.pop_front();
            if (got.sorted_value !== exp_res.sorted_value
                    || got.end_of_set !== exp_res.end_of_set
                    || got.dropped !== exp_res.dropped) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display(
                        "mismatch: expected %0d end %0b drop %0b, got %0d end %0b drop %0b",
                        exp_res.sorted_value, exp_res.end_of_set, exp_res.dropped,
                        got.sorted_value, got.end_of_set, got.dropped);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Expectations still queued at the end of the run are failures too.
        function void close_out();
            if (expected_q.size() != 0) begin
                errors += expected_q.size();
                $display("%0d expected results never arrived", expected_q.size());
            end
        endfunction
    endclass

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    t_in_item i_item;
    logic     busy;
    logic     o_result_valid;
    t_result  o_result;

    sorted_set_board board;
    int              sender_idle_pct;
    int              stall_cycles;
    int              elements_sent;
    int              sets_sent;
    int              overflow_sets;
    int              phase_items;

    heap_sort_engine #(
        .CAPACITY(CAPACITY)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .i_item        (i_item),
        .busy          (busy),
        .o_result_valid(o_result_valid),
        .o_result      (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Results are sampled at the rising edge that ends their strobe cycle.
    // The receiver cannot push back, so every strobe is a transfer.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid)
            board.check_result(o_result);
    end

    // The watchdog counts cycles in which neither an element nor a result is
    // transferred. Reset cycles do not count toward the limit.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Offers one element and returns once it has been transferred. Inputs only
    // change at the falling edge. The random wait before start rises puts gaps
    // at every point of the load, including right after the block frees up.
    task automatic send_element(input logic signed [31:0] value, input logic last);
        while ($urandom_range(99) < sender_idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start        = 1'b1;
        i_item.value = value;
        i_item.last  = last;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        board.note_element(i_item);
        elements_sent++;
        phase_items++;
        @(negedge i_clk);
        // Drop start right away so that a pause after this call cannot
        // resend the same element.
        start = 1'b0;
    endtask

    // A narrow set holds only values near zero. Otherwise roughly a third are
    // extremes or small numbers near zero, so that duplicates and sign boundaries
    // come up often. The rest are spread over the whole 32-bit range.
    function automatic logic signed [31:0] pick_value(bit narrow);
        if (narrow)
            return $signed($urandom_range(0, 12)) - 6;
        case ($urandom_range(9))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return $signed($urandom_range(0, 16)) - 8;
            default: return $signed($urandom());
        endcase
    endfunction

    task automatic send_random_set(input int set_size);
        bit narrow;
        narrow = ($urandom_range(3) == 0);
        for (int k = 0; k < set_size; k++)
            send_element(pick_value(narrow), k == set_size - 1);
        sets_sent++;
        if (set_size > CAPACITY)
            overflow_sets++;
    endtask

    // Holds the sender back until the block has delivered every result it owes.
    task automatic wait_for_drain();
        while (board.pending() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        int set_size;
        board           = new;
        start           = 1'b0;
        i_item          = '0;
        i_rst_n         = 1'b0;
        sender_idle_pct = 0;
        stall_cycles    = 0;
        elements_sent   = 0;
        sets_sent       = 0;
        overflow_sets   = 0;
        phase_items     = 0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed sets. A single element at either extreme gives the smallest
        // possible set. The mixed set crosses the sign boundary and both
        // extremes. A set of mostly equal values exercises the tie rules of the sift,
        // a descending set starts out as a valid max-heap, and a short ascending set
        // checks the trivial two-element case.
        sender_idle_pct = 36;
        send_element(VAL_MAX, 1'b1);
        send_element(VAL_MIN, 1'b1);
        send_element(VAL_MAX, 1'b0);
        send_element(VAL_MIN, 1'b0);
        send_element(32'sd0, 1'b0);
        send_element(-32'sd1, 1'b0);
        send_element(32'sd1, 1'b1);
        send_element(32'sd7, 1'b0);
        send_element(32'sd7, 1'b0);
        send_element(-32'sd7, 1'b0);
        send_element(32'sd7, 1'b0);
        send_element(32'sd7, 1'b1);
        for (int k = 9; k >= 4; k--)
            send_element(k, k == 4);
        send_element(-32'sd3, 1'b0);
        send_element(-32'sd2, 1'b1);
        sets_sent += 6;

        // Random part in three phases: the sender idles often, then more
        // often, then never. Most sets are short. A completely full set and
        // an overflowing one are the only long ones, because sort time grows
        // with set size. In the overflowing set the element marked last is
        // itself discarded, so the sort must start from the full store.
        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 45 : 0;
            phase_items     = 0;
            while (phase_items < 15) begin
                case ($urandom_range(19))
                    0, 1, 2, 3, 4:  set_size = $urandom_range(9, 20);
                    5:              set_size = $urandom_range(21, 40);
                    default:        set_size = $urandom_range(1, 8);
                endcase
                send_random_set(set_size);
                // Now and then the next set waits until the block is empty,
                // so that loading starts both during the trailing results and
                // from a fully idle block.
                if ($urandom_range(7) == 0)
                    wait_for_drain();
            end
            if (phase == 0)
                send_random_set(CAPACITY);
            else if (phase == 1)
                send_random_set(CAPACITY + $urandom_range(1, 3));
            // Between phases the sender always pauses for a full drain.
            wait_for_drain();
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        board.close_out();

        $display("covered %0d elements in %0d sets, %0d of them overflowing the store;",
                 elements_sent, sets_sent, overflow_sets);
        $display("%0d sorted results checked, %0d errors", board.results_checked,
                 board.errors);
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
rtl/core/hse_pkg.sv
rtl/core/hse_ram.sv
rtl/core/hse_datapath.sv
rtl/core/hse_ctrl.sv
rtl/core/heap_sort_engine.sv
bench/tb_heap_sort_engine.sv
